// ----- design/sorted_priority_queue_macros.svh -----
// Assertion macros for the sorted priority queue.
// Included by sorted_priority_queue, the file that carries concurrent assertions; needs clk and rst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Combinational property that must hold on every clock edge out of reset.
`define SPQ_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent on one edge implies consequent on the next edge.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define SPQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ----- design/spq_pkg.sv -----
// Shared types and constants of the sorted priority queue.
// No dependencies; used by spq_cell, sorted_priority_queue, spq_checker and the testbench.
`default_nettype none

package spq_pkg;

    localparam int DEPTH   = 32;
    localparam int VAL_W   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int FILL_W  = 6;

    localparam logic       OP_INSERT   = 1'b0;
    localparam logic       OP_REMOVE   = 1'b1;

    localparam logic [1:0] ST_INSERTED = 2'd0;
    localparam logic [1:0] ST_REMOVED  = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    typedef struct packed {
        logic                    en;
        logic                    op;
        logic signed [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic                    valid;
        logic                    gt;
        logic signed [VAL_W-1:0] value;
    } link_t;

endpackage

`default_nettype wire

// ----- design/sorted_priority_queue.sv -----
// Sorted priority queue: a chain of DEPTH cells kept in descending order.
// busy is high for 1 cycle; a new request is taken only while busy is low.
// The request is registered, then every cell updates at once and the result is registered.
// done is a one-cycle strobe; the receiver cannot stall.
// Reset (async, active low) empties the queue; no clearing pass is needed.
`default_nettype none
`include "sorted_priority_queue_macros.svh"

module sorted_priority_queue (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              req_type,
    input  wire logic signed [spq_pkg::VAL_W-1:0]  new_value,
    output logic                                   done,
    output logic [1:0]                             status,
    output logic signed [spq_pkg::VAL_W-1:0]       removed_value,
    output logic [spq_pkg::FILL_W-1:0]             fill_count
);

    logic                             pend_reg;
    logic                             op_reg;
    logic signed [spq_pkg::VAL_W-1:0] val_reg;
    logic [spq_pkg::CNT_W-1:0]        count_reg;
    logic [spq_pkg::CNT_W-1:0]        count_next;
    logic                             done_reg;
    logic [1:0]                       status_reg;
    logic [1:0]                       status_next;
    logic signed [spq_pkg::VAL_W-1:0] removed_reg;
    logic signed [spq_pkg::VAL_W-1:0] removed_next;

    logic                             full;
    logic                             empty;
    spq_pkg::cmd_t                    cmd;
    spq_pkg::link_t                   links [spq_pkg::DEPTH];
    spq_pkg::link_t                   head_link;
    spq_pkg::link_t                   tail_link;
    logic [spq_pkg::DEPTH-1:0]        valid_vec;

    assign full  = (count_reg == spq_pkg::CNT_W'(spq_pkg::DEPTH));
    assign empty = (count_reg == '0);

    assign cmd.en    = pend_reg && ((op_reg == spq_pkg::OP_INSERT) ? !full : !empty);
    assign cmd.op    = op_reg;
    assign cmd.value = val_reg;

    assign head_link.valid = 1'b0;
    assign head_link.gt    = 1'b1;
    assign head_link.value = '0;
    assign tail_link.valid = 1'b0;
    assign tail_link.gt    = 1'b0;
    assign tail_link.value = '0;

    for (genvar i = 0; i < spq_pkg::DEPTH; i++)
    begin : g_cell
        spq_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .left_in  ((i == 0) ? head_link : links[(i == 0) ? 0 : i - 1]),
            .right_in ((i == spq_pkg::DEPTH - 1) ? tail_link
                                                  : links[(i == spq_pkg::DEPTH - 1) ? i : i + 1]),
            .link_out (links[i])
        );
        assign valid_vec[i] = links[i].valid;
    end

    always_comb
    begin
        count_next   = count_reg;
        removed_next = '0;
        case (op_reg)
            spq_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    status_next = spq_pkg::ST_FULL;
                end
                else
                begin
                    status_next = spq_pkg::ST_INSERTED;
                    count_next  = count_reg + 1'b1;
                end
            end
            spq_pkg::OP_REMOVE:
            begin
                if (empty)
                begin
                    status_next = spq_pkg::ST_EMPTY;
                end
                else
                begin
                    status_next  = spq_pkg::ST_REMOVED;
                    removed_next = links[0].value;
                    count_next   = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_next = spq_pkg::ST_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            pend_reg <= start && !pend_reg;
            done_reg <= pend_reg;
            if (pend_reg)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !pend_reg)
        begin
            op_reg  <= req_type;
            val_reg <= new_value;
        end
        if (pend_reg)
        begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
        end
    end

    assign busy          = pend_reg;
    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign fill_count    = spq_pkg::FILL_W'(count_reg);

    `SPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= spq_pkg::CNT_W'(spq_pkg::DEPTH), "count above depth")
    `SPQ_ASSERT_ALWAYS(a_valid_matches_count, $countones(valid_vec) == int'(count_reg), "valid bits disagree with count")
    `SPQ_ASSERT_NEXT(a_result_follows, pend_reg, done_reg, "no result after request")
    `SPQ_ASSERT_IMPL(a_valid_prefix, links[0].valid == 1'b0, count_reg == '0, "head empty with nonzero count")

endmodule

`default_nettype wire

// ----- design/spq_cell.sv -----
// One storage cell of the sorted chain: holds a value and its valid bit.
// Depends on spq_pkg; trades values with its left and right neighbors.
`default_nettype none

module spq_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  spq_pkg::cmd_t      cmd,
    input  spq_pkg::link_t     left_in,
    input  spq_pkg::link_t     right_in,
    output spq_pkg::link_t     link_out
);

    logic                             valid_reg;
    logic                             valid_next;
    logic signed [spq_pkg::VAL_W-1:0] value_reg;
    logic signed [spq_pkg::VAL_W-1:0] value_next;
    logic                             gt;

    assign gt = valid_reg && (value_reg > cmd.value);

    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (cmd.en)
        begin
            case (cmd.op)
                spq_pkg::OP_INSERT:
                begin
                    if (!gt)
                    begin
                        if (left_in.gt)
                        begin
                            valid_next = 1'b1;
                            value_next = cmd.value;
                        end
                        else
                        begin
                            valid_next = left_in.valid;
                            value_next = left_in.value;
                        end
                    end
                end
                spq_pkg::OP_REMOVE:
                begin
                    valid_next = right_in.valid;
                    value_next = right_in.value;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign link_out.valid = valid_reg;
    assign link_out.gt    = gt;
    assign link_out.value = value_reg;

endmodule

`default_nettype wire

// ----- verif/spq_checker.sv -----
// Checker for the sorted priority queue: watches the request and result ports,
// keeps its own sorted copy of the queue and compares every result in order.
// Depends on spq_pkg for widths, request codes and status codes.
`timescale 1ns / 1ps

module spq_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             busy,
    input  wire logic                             req_type,
    input  wire logic signed [spq_pkg::VAL_W-1:0] new_value,
    input  wire logic                             done,
    input  wire logic [1:0]                       status,
    input  wire logic signed [spq_pkg::VAL_W-1:0] removed_value,
    input  wire logic [spq_pkg::FILL_W-1:0]       fill_count,
    output int                                    fail_count,
    output int                                    outstanding
);

    typedef struct packed {
        logic [1:0]                       status;
        logic signed [spq_pkg::VAL_W-1:0] removed;
        logic [spq_pkg::FILL_W-1:0]       fill;
    } answer_t;

    logic signed [spq_pkg::VAL_W-1:0] model_entries [spq_pkg::DEPTH];
    int                               model_count = 0;
    answer_t                          pending_answers [$];
    answer_t                          want;
    int                               n_fail = 0;
    int                               n_pending = 0;

    assign fail_count  = n_fail;
    assign outstanding = n_pending;

    function automatic answer_t predict_queue_op(input logic op,
                                                 input logic signed [spq_pkg::VAL_W-1:0] v);
        answer_t a;
        int      pos;
        int      i;
        a.removed = '0;
        if (op == spq_pkg::OP_INSERT)
        begin
            if (model_count >= spq_pkg::DEPTH)
            begin
                a.status = spq_pkg::ST_FULL;
            end
            else
            begin
                pos = 0;
                while (pos < model_count && model_entries[pos] > v)
                    pos++;
                for (i = model_count; i > pos; i--)
                    model_entries[i] = model_entries[i-1];
                model_entries[pos] = v;
                model_count++;
                a.status = spq_pkg::ST_INSERTED;
            end
        end
        else
        begin
            if (model_count == 0)
            begin
                a.status = spq_pkg::ST_EMPTY;
            end
            else
            begin
                a.removed = model_entries[0];
                for (i = 1; i < model_count; i++)
                    model_entries[i-1] = model_entries[i];
                model_count--;
                a.status = spq_pkg::ST_REMOVED;
            end
        end
        a.fill = model_count[spq_pkg::FILL_W-1:0];
        return a;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_answers.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: unexpected result status=%0d removed=%0d fill=%0d",
                                 $realtime, status, removed_value, fill_count);
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (status !== want.status || removed_value !== want.removed ||
                        fill_count !== want.fill)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display({"%0t: mismatch status exp %0d got %0d, removed exp %0d ",
                                      "got %0d, fill exp %0d got %0d"},
                                     $realtime, want.status, status, want.removed,
                                     removed_value, want.fill, fill_count);
                    end
                end
            end
            if (start && !busy)
                pending_answers.push_back(predict_queue_op(req_type, new_value));
            n_pending = pending_answers.size();
        end
    end

endmodule

// ----- verif/tb_sorted_priority_queue.sv -----
// Testbench top for the sorted priority queue: clock, reset, directed and random
// requests with random gaps, watchdog and verdict. Checking is done by spq_checker.
// Depends on spq_pkg, spq_checker and sorted_priority_queue.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 650;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             req_type = spq_pkg::OP_INSERT;
    logic signed [spq_pkg::VAL_W-1:0] new_value = '0;
    logic                             busy;
    logic                             done;
    logic [1:0]                       status;
    logic signed [spq_pkg::VAL_W-1:0] removed_value;
    logic [spq_pkg::FILL_W-1:0]       fill_count;
    int                               fail_count;
    int                               outstanding;
    int                               idle_cycles = 0;
    bit                               quiet = 1'b0;

    always #5 clk = ~clk;

    sorted_priority_queue DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .new_value     (new_value),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .fill_count    (fill_count)
    );

    spq_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .new_value     (new_value),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .fill_count    (fill_count),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("sorted_priority_queue test failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    function automatic logic signed [spq_pkg::VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return spq_pkg::VAL_W'($urandom_range(0, 3) - 2);
            3, 4:    return spq_pkg::VAL_W'($urandom_range(0, 7) - 4);
            default: return spq_pkg::VAL_W'($urandom());
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance, or after a random gap with start low
    task automatic send_request(input logic op, input logic signed [spq_pkg::VAL_W-1:0] v);
        int gap;
        start     <= 1'b1;
        req_type  <= op;
        new_value <= v;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            start     <= 1'b0;
            req_type  <= 1'($urandom_range(0, 1));
            new_value <= spq_pkg::VAL_W'($urandom());
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int sent;
        int phase_len;
        int ins_pct;
        int k;

        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty removal, extremes, equal values, bit patterns, drain
        send_request(spq_pkg::OP_REMOVE, 16'sh1234);
        send_request(spq_pkg::OP_INSERT, 16'sh0000);
        send_request(spq_pkg::OP_INSERT, 16'sh7FFF);
        send_request(spq_pkg::OP_INSERT, 16'sh8000);
        send_request(spq_pkg::OP_INSERT, 16'shFFFF);
        send_request(spq_pkg::OP_INSERT, 16'sh0001);
        send_request(spq_pkg::OP_INSERT, 16'sh0000);
        send_request(spq_pkg::OP_INSERT, 16'sh7FFF);
        send_request(spq_pkg::OP_REMOVE, 16'sh0000);
        send_request(spq_pkg::OP_REMOVE, 16'shFFFF);
        send_request(spq_pkg::OP_REMOVE, 16'sh0000);
        send_request(spq_pkg::OP_INSERT, 16'sh5555);
        send_request(spq_pkg::OP_INSERT, 16'shAAAA);
        send_request(spq_pkg::OP_INSERT, 16'sh8000);
        for (k = 0; k < 8; k++)
            send_request(spq_pkg::OP_REMOVE, spq_pkg::VAL_W'($urandom()));
        drain_results();

        sent = 0;
        while (sent < TARGET_ITEMS)
        begin
            case ($urandom_range(0, 2))
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                default: ins_pct = 50;
            endcase
            quiet     = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(40, 80);
            for (k = 0; k < phase_len; k++)
            begin
                if ($urandom_range(0, 99) < ins_pct)
                    send_request(spq_pkg::OP_INSERT, pick_value());
                else
                    send_request(spq_pkg::OP_REMOVE, spq_pkg::VAL_W'($urandom()));
                sent++;
            end
            quiet = 1'b0;
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("sorted_priority_queue test passed");
        else
            $display("sorted_priority_queue test failed");
        $finish;
    end

endmodule
